FILE: src/bko_pkg.sv
// Shared constants, types and helpers for the B-spline knot insertion block.
// Used by the channel interfaces, the weight chain, the divider and the top level.
// Depends on nothing.
package bko_pkg;

   localparam int MAX_ORDER      = 8;
   localparam int MAX_OLD_POINTS = 64;
   localparam int MAX_NEW_KNOTS  = 128;
   localparam int OLD_KNOT_DEPTH = MAX_OLD_POINTS + MAX_ORDER;

   // One cell per weight slot plus one spare that absorbs the discarded entry.
   localparam int CHAIN_LEN = MAX_ORDER + 1;
   localparam int COORDS    = 4;

   localparam int OP_W       = 2;
   localparam int IDX_W      = 7;
   localparam int DATA_W     = 32;
   localparam int ORD_W      = 4;
   localparam int NPT_W      = 7;
   localparam int NKC_W      = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam int OKA_W = $clog2(OLD_KNOT_DEPTH);
   localparam int NKA_W = $clog2(MAX_NEW_KNOTS);
   localparam int CPA_W = $clog2(MAX_OLD_POINTS);
   localparam int CNT_W = $clog2(CHAIN_LEN + 1);
   localparam int IX_W  = OKA_W + 2;
   localparam int TRM_W = 34;
   localparam int ACC_W = TRM_W + $clog2(MAX_ORDER) + 1;

   localparam logic signed [DATA_W-1:0] WEIGHT_ONE = 32'sh4000_0000;
   localparam logic signed [DATA_W-1:0] DATA_MAX   = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] DATA_MIN   = 32'sh8000_0000;

   localparam logic [ORD_W-1:0] CURVE_ORDER_RESET     = 4'd4;
   localparam logic [NPT_W-1:0] OLD_POINT_COUNT_RESET = 7'd4;
   localparam logic [NKC_W-1:0] NEW_KNOT_COUNT_RESET  = 8'd8;

   localparam logic [CSR_IDX_W-1:0] CSR_CURVE_ORDER     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OLD_POINT_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEW_KNOT_COUNT  = 2'd2;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_OLD   = 2'd0,
      OP_LOAD_NEW   = 2'd1,
      OP_LOAD_POINT = 2'd2,
      OP_COMPUTE    = 2'd3
   } op_type;

   typedef struct packed {
      logic init;
      logic shift;
   } chain_ctl_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] z;
      logic signed [DATA_W-1:0] w;
   } point_type;

   function automatic logic signed [DATA_W-1:0] clip33(input logic signed [DATA_W:0] v);
      logic signed [DATA_W-1:0] r;
      if (v[DATA_W] != v[DATA_W-1]) begin
         r = v[DATA_W] ? DATA_MIN : DATA_MAX;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: src/bko_req_if.sv
// Request channel: load and compute items with valid/ready handshake.
// Depends on bko_pkg.
interface bko_req_if;
   import bko_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic [IDX_W-1:0]         item_index;
   logic signed [DATA_W-1:0] knot_value;
   logic signed [DATA_W-1:0] coord_x;
   logic signed [DATA_W-1:0] coord_y;
   logic signed [DATA_W-1:0] coord_z;
   logic signed [DATA_W-1:0] coord_w;

   modport source (output valid, op, item_index, knot_value, coord_x, coord_y, coord_z,
                   coord_w, input ready);
   modport sink (input valid, op, item_index, knot_value, coord_x, coord_y, coord_z,
                 coord_w, output ready);
endinterface

FILE: src/bko_rsp_if.sv
// Result channel: one refined control point per compute item whose index is in range.
// Depends on bko_pkg.
interface bko_rsp_if;
   import bko_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [IDX_W-1:0]         point_index;
   logic signed [DATA_W-1:0] out_x;
   logic signed [DATA_W-1:0] out_y;
   logic signed [DATA_W-1:0] out_z;
   logic signed [DATA_W-1:0] out_w;
   logic                     saturated;

   modport source (output valid, point_index, out_x, out_y, out_z, out_w, saturated,
                   input ready);
   modport sink (input valid, point_index, out_x, out_y, out_z, out_w, saturated,
                 output ready);
endinterface

FILE: src/bspline_knot_insertion_oslo.sv
// Top level of the Oslo knot insertion block: knot and point stores, sequencer,
// weight chain, shared multiplier and divider. Depends on bko_pkg, bko_req_if,
// bko_rsp_if, bko_alpha_chain and bko_divider.
//
//   Port group  Dir  Handshake         Carries
//   req_bus     in   valid/ready       op, item_index, knot_value, coord_x..coord_w
//   rsp_bus     out  valid/ready       point_index, out_x..out_w, saturated
//   csr_*       in   csr_we, no wait   csr_index, csr_wdata
//
// Each recurrence term makes two passes through the single divider, which
// yields one quotient bit per cycle.
// Reset is synchronous and leaves the stores unwritten; no clearing pass is run.
// New items are taken only between computes; a finished result waits in the
// output register and a pending one stalls the sequencer until it transfers.
module bspline_knot_insertion_oslo (
   input  logic                              clock,
   input  logic                              reset,
   bko_req_if.sink                           req_bus,
   bko_rsp_if.source                         rsp_bus,
   input  logic                              csr_we,
   input  logic [bko_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bko_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bko_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_TJ, S_MU, S_MU_END, S_MU_FIX, S_RNEW, S_RTJ, S_SWEEP, S_DIFF,
      S_MUL2, S_DIV2_GO, S_DIV2_WAIT, S_MUL1, S_DIV1_GO, S_DIV1_WAIT,
      S_OINIT, S_OSWEEP, S_OMUL, S_OFIN
   } state_type;

   // Configuration registers
   logic [ORD_W-1:0] curve_order_ff;
   logic [NPT_W-1:0] old_point_count_ff;
   logic [NKC_W-1:0] new_knot_count_ff;

   // Stores
   logic signed [DATA_W-1:0] old_mem [OLD_KNOT_DEPTH];
   logic signed [DATA_W-1:0] new_mem [MAX_NEW_KNOTS];
   point_type                ctrl_mem [MAX_OLD_POINTS];
   logic signed [DATA_W-1:0] old_a_rd_ff, old_b_rd_ff, new_rd_ff;
   point_type                ctrl_rd_ff;
   logic [OKA_W-1:0]         old_addr_a, old_addr_b;
   logic [NKA_W-1:0]         new_addr;
   logic [CPA_W-1:0]         ctrl_addr;

   // Sequencer registers
   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         j_ff, j_in;
   logic signed [DATA_W-1:0] tj_ff, tj_in;
   logic [OKA_W-1:0]         mu_ff, mu_in;
   logic [NPT_W-1:0]         cnt_ff, cnt_in;
   logic                     cmp_valid_ff, cmp_valid_in;
   logic [NPT_W-1:0]         cmp_idx_ff, cmp_idx_in;
   logic [ORD_W-1:0]         r_ff, r_in;
   logic [CNT_W-1:0]         t_ff, t_in;
   logic [1:0]               c_ff, c_in;
   logic signed [DATA_W-1:0] carry_ff, carry_in;
   logic signed [DATA_W-1:0] d1_ff, d1_in;
   logic signed [DATA_W-1:0] d2_ff, d2_in;
   logic signed [DATA_W-1:0] q2_ff, q2_in;
   logic signed [2*DATA_W-1:0] prod_ff, prod_in;
   logic                     pvalid_ff, pvalid_in;
   logic [1:0]               pc_ff, pc_in;
   logic signed [ACC_W-1:0]  acc_ff [COORDS];
   logic signed [ACC_W-1:0]  acc_in [COORDS];
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]         rsp_index_ff, rsp_index_in;
   point_type                rsp_point_ff, rsp_point_in;
   logic                     rsp_sat_ff, rsp_sat_in;

   // Datapath wires
   logic [ORD_W-1:0]         k_use;
   logic [NPT_W-1:0]         n_use;
   logic [NKC_W-1:0]         q_use;
   logic                     req_take;
   logic                     compute_ok;
   logic [IX_W-1:0]          ix, ixr;
   logic [IDX_W:0]           jr;
   chain_ctl_type            chain_ctl;
   logic signed [DATA_W-1:0] tail_in;
   logic signed [DATA_W-1:0] head;
   logic signed [DATA_W-1:0] mul_a, mul_b;
   logic signed [DATA_W:0]   span;
   logic                     div_start, div_done;
   logic signed [DATA_W-1:0] div_quot;
   logic signed [2*DATA_W-1:0] rounded;
   logic signed [TRM_W-1:0]  out_term;
   logic signed [DATA_W-1:0] sat_val [COORDS];
   logic                     sat_hit [COORDS];

   // Registers are used clamped to their legal ranges.
   always_comb begin
      if (curve_order_ff == '0) begin
         k_use = ORD_W'(1);
      end else if (curve_order_ff > ORD_W'(MAX_ORDER)) begin
         k_use = ORD_W'(MAX_ORDER);
      end else begin
         k_use = curve_order_ff;
      end
      if (old_point_count_ff == '0) begin
         n_use = NPT_W'(1);
      end else if (old_point_count_ff > NPT_W'(MAX_OLD_POINTS)) begin
         n_use = NPT_W'(MAX_OLD_POINTS);
      end else begin
         n_use = old_point_count_ff;
      end
      if (new_knot_count_ff < NKC_W'(2)) begin
         q_use = NKC_W'(2);
      end else if (new_knot_count_ff > NKC_W'(MAX_NEW_KNOTS)) begin
         q_use = NKC_W'(MAX_NEW_KNOTS);
      end else begin
         q_use = new_knot_count_ff;
      end
   end

   assign req_take   = req_bus.valid && req_bus.ready;
   assign compute_ok = (q_use > NKC_W'(k_use)) &&
                       (NKC_W'(req_bus.item_index) < (q_use - NKC_W'(k_use)));

   // The head cell at sweep position t holds the weight of old index mu + 1 + t - CHAIN_LEN.
   assign ix  = IX_W'(mu_ff) + IX_W'(t_ff) + IX_W'(1) - IX_W'(CHAIN_LEN);
   assign ixr = ix + IX_W'(r_ff);
   assign jr  = (IDX_W + 1)'(j_ff) + (IDX_W + 1)'(r_ff);

   assign old_addr_a = (state_ff == S_MU) ? OKA_W'(cnt_ff) : ix[OKA_W-1:0];
   assign old_addr_b = ixr[OKA_W-1:0];
   assign new_addr   = (state_ff == S_IDLE) ? NKA_W'(req_bus.item_index) : jr[NKA_W-1:0];
   assign ctrl_addr  = ix[CPA_W-1:0];

   // Knot and point stores
   always_ff @(posedge clock) begin
      if (req_take && req_bus.op == OP_LOAD_OLD &&
          OKA_W'(req_bus.item_index) < OKA_W'(OLD_KNOT_DEPTH)) begin
         old_mem[OKA_W'(req_bus.item_index)] <= req_bus.knot_value;
      end
      old_a_rd_ff <= old_mem[old_addr_a];
      old_b_rd_ff <= old_mem[old_addr_b];
   end

   always_ff @(posedge clock) begin
      if (req_take && req_bus.op == OP_LOAD_NEW) begin
         new_mem[NKA_W'(req_bus.item_index)] <= req_bus.knot_value;
      end
      new_rd_ff <= new_mem[new_addr];
   end

   always_ff @(posedge clock) begin
      if (req_take && req_bus.op == OP_LOAD_POINT &&
          (IDX_W + 1)'(req_bus.item_index) < (IDX_W + 1)'(MAX_OLD_POINTS)) begin
         ctrl_mem[CPA_W'(req_bus.item_index)] <= '{x: req_bus.coord_x, y: req_bus.coord_y,
                                                   z: req_bus.coord_z, w: req_bus.coord_w};
      end
      ctrl_rd_ff <= ctrl_mem[ctrl_addr];
   end

   bko_alpha_chain u_chain (
      .clock   (clock),
      .ctl     (chain_ctl),
      .tail_in (tail_in),
      .head    (head)
   );

   assign span = {d1_ff[DATA_W-1], d1_ff} + {d2_ff[DATA_W-1], d2_ff};

   bko_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (span),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Output term: round the Q2.30 x Q16.16 product to Q16.16, floor after adding half.
   assign rounded  = prod_ff + 64'sd536870912;
   assign out_term = rounded[2*DATA_W-1:30];

   always_comb begin
      for (int i = 0; i < COORDS; i++) begin
         sat_hit[i] = 1'b0;
         if (acc_ff[i] > ACC_W'(DATA_MAX)) begin
            sat_val[i] = DATA_MAX;
            sat_hit[i] = 1'b1;
         end else if (acc_ff[i] < ACC_W'(DATA_MIN)) begin
            sat_val[i] = DATA_MIN;
            sat_hit[i] = 1'b1;
         end else begin
            sat_val[i] = acc_ff[i][DATA_W-1:0];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      j_in         = j_ff;
      tj_in        = tj_ff;
      mu_in        = mu_ff;
      cnt_in       = cnt_ff;
      r_in         = r_ff;
      t_in         = t_ff;
      c_in         = c_ff;
      carry_in     = carry_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      q2_in        = q2_ff;
      pvalid_in    = 1'b0;
      pc_in        = pc_ff;
      acc_in       = acc_ff;
      rsp_index_in = rsp_index_ff;
      rsp_point_in = rsp_point_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      chain_ctl    = '0;
      tail_in      = carry_ff;
      div_start    = 1'b0;
      mul_a        = head;
      mul_b        = '0;

      // Search for mu: each compare comes in the cycle after its knot read.
      cmp_valid_in = state_ff == S_MU;
      cmp_idx_in   = cnt_ff;
      if (cmp_valid_ff && tj_ff >= old_a_rd_ff) begin
         mu_in = OKA_W'(cmp_idx_ff);
      end

      if (pvalid_ff) begin
         acc_in[pc_ff] = acc_ff[pc_ff] + ACC_W'(out_term);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take && req_bus.op == OP_COMPUTE && compute_ok) begin
               j_in           = req_bus.item_index;
               mu_in          = '0;
               chain_ctl.init = 1'b1;
               state_in       = S_TJ;
            end
         end
         S_TJ: begin
            tj_in    = new_rd_ff;
            cnt_in   = '0;
            state_in = S_MU;
         end
         S_MU: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == n_use - 1'b1) begin
               state_in = S_MU_END;
            end
         end
         S_MU_END: state_in = S_MU_FIX;
         S_MU_FIX: begin
            if (mu_ff < OKA_W'(k_use - 1'b1)) begin
               mu_in = OKA_W'(k_use - 1'b1);
            end
            r_in     = ORD_W'(1);
            state_in = (k_use == ORD_W'(1)) ? S_OINIT : S_RNEW;
         end
         S_RNEW: begin
            t_in     = '0;
            carry_in = '0;
            state_in = S_RTJ;
         end
         S_RTJ: begin
            tj_in    = new_rd_ff;
            state_in = S_SWEEP;
         end
         S_SWEEP: begin
            if (t_ff == CNT_W'(CHAIN_LEN)) begin
               // Enter the last carry; the oldest entry drops out of the head.
               chain_ctl.shift = 1'b1;
               if (r_ff == k_use - 1'b1) begin
                  state_in = S_OINIT;
               end else begin
                  r_in     = r_ff + 1'b1;
                  state_in = S_RNEW;
               end
            end else if (t_ff < CNT_W'(CHAIN_LEN) - CNT_W'(r_ff)) begin
               // Slots still known to be zero pass straight through.
               chain_ctl.shift = 1'b1;
               carry_in        = '0;
               t_in            = t_ff + 1'b1;
            end else begin
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            d1_in    = clip33({tj_ff[DATA_W-1], tj_ff} - {old_a_rd_ff[DATA_W-1], old_a_rd_ff});
            d2_in    = clip33({old_b_rd_ff[DATA_W-1], old_b_rd_ff} - {tj_ff[DATA_W-1], tj_ff});
            state_in = S_MUL2;
         end
         S_MUL2: begin
            mul_b    = d2_ff;
            state_in = S_DIV2_GO;
         end
         S_DIV2_GO: begin
            div_start = 1'b1;
            state_in  = S_DIV2_WAIT;
         end
         S_DIV2_WAIT: begin
            if (div_done) begin
               q2_in    = div_quot;
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            mul_b    = d1_ff;
            state_in = S_DIV1_GO;
         end
         S_DIV1_GO: begin
            div_start = 1'b1;
            state_in  = S_DIV1_WAIT;
         end
         S_DIV1_WAIT: begin
            if (div_done) begin
               tail_in         = clip33({q2_ff[DATA_W-1], q2_ff} +
                                        {carry_ff[DATA_W-1], carry_ff});
               chain_ctl.shift = 1'b1;
               carry_in        = div_quot;
               t_in            = t_ff + 1'b1;
               state_in        = S_SWEEP;
            end
         end
         S_OINIT: begin
            for (int i = 0; i < COORDS; i++) begin
               acc_in[i] = '0;
            end
            t_in     = '0;
            state_in = S_OSWEEP;
         end
         S_OSWEEP: begin
            tail_in = '0;
            if (t_ff == CNT_W'(CHAIN_LEN)) begin
               state_in = S_OFIN;
            end else if (t_ff < CNT_W'(CHAIN_LEN) - CNT_W'(k_use)) begin
               chain_ctl.shift = 1'b1;
               t_in            = t_ff + 1'b1;
            end else begin
               c_in     = '0;
               state_in = S_OMUL;
            end
         end
         S_OMUL: begin
            tail_in = '0;
            unique case (c_ff)
               2'd0: mul_b = ctrl_rd_ff.x;
               2'd1: mul_b = ctrl_rd_ff.y;
               2'd2: mul_b = ctrl_rd_ff.z;
               2'd3: mul_b = ctrl_rd_ff.w;
               default: mul_b = '0;
            endcase
            pvalid_in = 1'b1;
            pc_in     = c_ff;
            c_in      = c_ff + 1'b1;
            if (c_ff == 2'd3) begin
               chain_ctl.shift = 1'b1;
               t_in            = t_ff + 1'b1;
               state_in        = S_OSWEEP;
            end
         end
         S_OFIN: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = j_ff;
               rsp_point_in = '{x: sat_val[0], y: sat_val[1], z: sat_val[2], w: sat_val[3]};
               rsp_sat_in   = sat_hit[0] || sat_hit[1] || sat_hit[2] || sat_hit[3];
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= S_IDLE;
         cmp_valid_ff       <= 1'b0;
         pvalid_ff          <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         curve_order_ff     <= CURVE_ORDER_RESET;
         old_point_count_ff <= OLD_POINT_COUNT_RESET;
         new_knot_count_ff  <= NEW_KNOT_COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         cmp_valid_ff <= cmp_valid_in;
         pvalid_ff    <= pvalid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_CURVE_ORDER:     curve_order_ff     <= csr_wdata[ORD_W-1:0];
               CSR_OLD_POINT_COUNT: old_point_count_ff <= csr_wdata[NPT_W-1:0];
               CSR_NEW_KNOT_COUNT:  new_knot_count_ff  <= csr_wdata[NKC_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      j_ff         <= j_in;
      tj_ff        <= tj_in;
      mu_ff        <= mu_in;
      cnt_ff       <= cnt_in;
      cmp_idx_ff   <= cmp_idx_in;
      r_ff         <= r_in;
      t_ff         <= t_in;
      c_ff         <= c_in;
      carry_ff     <= carry_in;
      d1_ff        <= d1_in;
      d2_ff        <= d2_in;
      q2_ff        <= q2_in;
      prod_ff      <= prod_in;
      pc_ff        <= pc_in;
      acc_ff       <= acc_in;
      rsp_index_ff <= rsp_index_in;
      rsp_point_ff <= rsp_point_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign req_bus.ready       = state_ff == S_IDLE;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.point_index = rsp_index_ff;
   assign rsp_bus.out_x       = rsp_point_ff.x;
   assign rsp_bus.out_y       = rsp_point_ff.y;
   assign rsp_bus.out_z       = rsp_point_ff.z;
   assign rsp_bus.out_w       = rsp_point_ff.w;
   assign rsp_bus.saturated   = rsp_sat_ff;

endmodule

FILE: src/bko_alpha_cell.sv
// One weight cell of the recurrence chain: holds a Q2.30 weight and takes its
// neighbor's value on a shift. Depends on bko_pkg.
module bko_alpha_cell (
   input  logic                              clock,
   input  bko_pkg::chain_ctl_type            ctl,
   input  logic signed [bko_pkg::DATA_W-1:0] init_value,
   input  logic signed [bko_pkg::DATA_W-1:0] shift_in,
   output logic signed [bko_pkg::DATA_W-1:0] value
);
   import bko_pkg::*;

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.init) begin
         value_in = init_value;
      end else if (ctl.shift) begin
         value_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

FILE: src/bko_alpha_chain.sv
// Row of weight cells. Each shift moves every weight one cell toward the head
// and enters a new weight at the tail. Depends on bko_pkg and bko_alpha_cell.
module bko_alpha_chain (
   input  logic                              clock,
   input  bko_pkg::chain_ctl_type            ctl,
   input  logic signed [bko_pkg::DATA_W-1:0] tail_in,
   output logic signed [bko_pkg::DATA_W-1:0] head
);
   import bko_pkg::*;

   logic signed [DATA_W-1:0] cell_value [CHAIN_LEN];

   for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_cell
      logic signed [DATA_W-1:0] init_value;
      logic signed [DATA_W-1:0] shift_in;

      // The tail cell holds the weight of the highest slot, which starts at one.
      assign init_value = (i == CHAIN_LEN - 1) ? WEIGHT_ONE : '0;
      if (i == CHAIN_LEN - 1) begin : g_tail
         assign shift_in = tail_in;
      end else begin : g_body
         assign shift_in = cell_value[i + 1];
      end

      bko_alpha_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .init_value (init_value),
         .shift_in   (shift_in),
         .value      (cell_value[i])
      );
   end

   assign head = cell_value[0];

endmodule

FILE: src/bko_divider.sv
// Radix-2 restoring divider for one recurrence term: signed 64-bit product over
// a signed 33-bit knot span, truncated and saturated to 32 bits. Depends on bko_pkg.
module bko_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [2*bko_pkg::DATA_W-1:0] dividend,
   input  logic signed [bko_pkg::DATA_W:0]   divisor,
   output logic                              done,
   output logic signed [bko_pkg::DATA_W-1:0] quotient
);
   import bko_pkg::*;

   typedef enum logic [1:0] {D_IDLE, D_CHECK, D_RUN, D_FIN} dstate_type;

   localparam logic [DATA_W-1:0] NEG_LIMIT = 32'h8000_0000;

   dstate_type                 state_ff, state_in;
   logic [2*DATA_W-1:0]        np_ff, np_in;
   logic [DATA_W:0]            ns_ff, ns_in;
   logic                       neg_ff, neg_in;
   logic                       zero_ff, zero_in;
   logic [DATA_W+1:0]          rem_ff, rem_in;
   logic [DATA_W-1:0]          quo_ff, quo_in;
   logic [$clog2(DATA_W)-1:0]  cnt_ff, cnt_in;
   logic signed [DATA_W-1:0]   quot_ff, quot_in;
   logic                       done_ff, done_in;

   logic [DATA_W+1:0]          rem_shift;
   logic                       fits;

   always_comb begin
      state_in  = state_ff;
      np_in     = np_ff;
      ns_in     = ns_ff;
      neg_in    = neg_ff;
      zero_in   = zero_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      quot_in   = quot_ff;
      done_in   = 1'b0;
      rem_shift = {rem_ff[DATA_W:0], quo_ff[DATA_W-1]};
      fits      = rem_shift >= {1'b0, ns_ff};

      unique case (state_ff)
         D_IDLE: begin
            if (start) begin
               np_in    = dividend[2*DATA_W-1] ? 64'(-dividend) : 64'(dividend);
               ns_in    = divisor[DATA_W] ? 33'(-divisor) : 33'(divisor);
               neg_in   = dividend[2*DATA_W-1] ^ divisor[DATA_W];
               zero_in  = divisor == '0;
               state_in = D_CHECK;
            end
         end
         D_CHECK: begin
            // A quotient of 2^32 or more saturates without iterating.
            if (zero_ff) begin
               quot_in  = '0;
               done_in  = 1'b1;
               state_in = D_IDLE;
            end else if ({1'b0, np_ff} >= {ns_ff, {DATA_W{1'b0}}}) begin
               quot_in  = neg_ff ? DATA_MIN : DATA_MAX;
               done_in  = 1'b1;
               state_in = D_IDLE;
            end else begin
               rem_in   = {2'b00, np_ff[2*DATA_W-1:DATA_W]};
               quo_in   = np_ff[DATA_W-1:0];
               cnt_in   = '1;
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            rem_in = fits ? rem_shift - {1'b0, ns_ff} : rem_shift;
            quo_in = {quo_ff[DATA_W-2:0], fits};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = D_FIN;
            end
         end
         D_FIN: begin
            if (!neg_ff) begin
               quot_in = quo_ff[DATA_W-1] ? DATA_MAX : quo_ff;
            end else begin
               quot_in = (quo_ff > NEG_LIMIT) ? DATA_MIN : -quo_ff;
            end
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      np_ff   <= np_in;
      ns_ff   <= ns_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule
